[rtl/per_key_bounded_history_buffer_core_defines.svh]
// Assertion macros for the history buffer core.
`ifndef PER_KEY_BOUNDED_HISTORY_BUFFER_CORE_DEFINES_SVH
`define PER_KEY_BOUNDED_HISTORY_BUFFER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define PBHB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pbhb assertion failed");
// Checked on every rising clock edge, reset included.
`define PBHB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("pbhb assertion failed");
`else
`define PBHB_ASSERT(lbl, prop)
`define PBHB_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/pbhb_pkg.sv]
`timescale 1ns / 1ps
package pbhb_pkg;

  localparam int NumUnits  = 64;
  localparam int Depth     = 16;
  localparam int WordWidth = 32;

  localparam int UnitW = (NumUnits > 1) ? $clog2(NumUnits) : 1;
  localparam int SlotW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int AddrW = $clog2(NumUnits * Depth);

  // Port field widths
  localparam int MaxEntW   = 5;
  localparam int OpW       = 3;
  localparam int UnitIdW   = 6;
  localparam int OffW      = 5;
  localparam int PosWordW  = 32;
  localparam int StatusW   = 2;
  localparam int ReadWordW = 32;
  localparam int EntCntW   = 5;
  localparam int InDataW   = 48;
  localparam int OutDataW  = 40;

  localparam logic [MaxEntW-1:0] MaxEntReset = 5'd16;

  // Operation codes
  localparam logic [OpW-1:0] OP_LOG     = 3'd0;
  localparam logic [OpW-1:0] OP_READ    = 3'd1;
  localparam logic [OpW-1:0] OP_COUNT   = 3'd2;
  localparam logic [OpW-1:0] OP_CLR_KEY = 3'd3;
  localparam logic [OpW-1:0] OP_CLR_ALL = 3'd4;

  // Status codes
  localparam logic [StatusW-1:0] STAT_OK     = 2'd0;
  localparam logic [StatusW-1:0] STAT_NO_KEY = 2'd1;
  localparam logic [StatusW-1:0] STAT_RANGE  = 2'd2;

  typedef struct packed {
    logic             we;
    logic             clr_one;
    logic             clr_all;
    logic [UnitW-1:0] unit;
    logic [SlotW-1:0] oldest;
    logic [CntW-1:0]  count;
  } meta_wr_t;

  typedef struct packed {
    logic             present;
    logic [SlotW-1:0] oldest;
    logic [CntW-1:0]  count;
  } meta_rd_t;

endpackage

[rtl/pbhb_meta_store.sv]
`timescale 1ns / 1ps
module pbhb_meta_store
  import pbhb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [UnitW-1:0] rd_unit_i,
  input  meta_wr_t         wr_i,
  output meta_rd_t         rd_o
);

  logic [SlotW+CntW-1:0] mem_q [NumUnits];
  logic [NumUnits-1:0]   valid_q;
  logic [SlotW+CntW-1:0] rd_data_q;
  logic                  rd_valid_q;

  // per-key ring pointer and fill level
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.unit] <= {wr_i.oldest, wr_i.count};
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_unit_i];
    end
  end

  // valid bit doubles as key-present; invalid reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_unit_i];
      end
      if (wr_i.clr_all) begin
        valid_q <= '0;
      end else if (wr_i.clr_one) begin
        valid_q[wr_i.unit] <= 1'b0;
      end else if (wr_i.we) begin
        valid_q[wr_i.unit] <= 1'b1;
      end
    end
  end

  assign rd_o.present = rd_valid_q;
  assign rd_o.oldest  = rd_valid_q ? rd_data_q[SlotW+CntW-1:CntW] : '0;
  assign rd_o.count   = rd_valid_q ? rd_data_q[CntW-1:0] : '0;

endmodule

[rtl/pbhb_word_store.sv]
`timescale 1ns / 1ps
module pbhb_word_store
  import pbhb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [WordWidth-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [WordWidth-1:0] rdata_o
);

  logic [WordWidth-1:0] mem_q [NumUnits*Depth];
  logic [WordWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/per_key_bounded_history_buffer_core.sv]
`timescale 1ns / 1ps
// Flow: an item taken in ST_IDLE starts the registered metadata read; ST_META registers the
// result, or for a read that hits starts the registered history-word read, and ST_DATA
// registers the result from it. Registering a result waits until the held one is taken, and
// no new item is accepted before the state is back in ST_IDLE.
// Reset: async active low; all keys absent, max_entries back to 16. History words
// are not cleared, only ever read after being written.
`include "per_key_bounded_history_buffer_core_defines.svh"
module per_key_bounded_history_buffer_core
  import pbhb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // config: max_entries
  input  logic                cfg_we_i,
  input  logic [MaxEntW-1:0]  cfg_wdata_i,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [2:0] op, [8:3] unit_id, [13:9] offset, [45:14] position_word, [47:46] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] status, [33:2] read_word, [38:34] entry_count, [39] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int PosW = ((CntW > OffW) ? CntW : OffW) + 2;

  typedef enum logic [1:0] {ST_IDLE, ST_META, ST_DATA} state_e;

  // ring slot arithmetic: s is below 2*Depth
  function automatic logic [SlotW-1:0] slot_wrap(input logic [CntW:0] s);
    if (s >= (CntW+1)'(Depth)) begin
      return SlotW'(s - (CntW+1)'(Depth));
    end
    return SlotW'(s);
  endfunction

  state_e state_q;
  logic   out_valid_q;

  logic [MaxEntW-1:0] max_entries_q;

  // captured item
  logic [OpW-1:0]          op_q;
  logic [UnitIdW-1:0]      unit_q;
  logic signed [OffW-1:0]  off_q;
  logic [PosWordW-1:0]     pword_q;

  // result register
  logic [StatusW-1:0]   out_status_q;
  logic [ReadWordW-1:0] out_word_q;
  logic [EntCntW-1:0]   out_cnt_q;

  logic                 in_take;
  logic                 proceed;
  logic                 load_meta;
  logic                 load_data;
  logic                 unit_ok;
  meta_rd_t             meta_rd;
  meta_wr_t             meta_wr;

  logic [CntW-1:0]      limit_c;
  logic [CntW-1:0]      cnt_c;
  logic [SlotW-1:0]     old_c;
  logic [SlotW-1:0]     wslot_c;
  logic [SlotW-1:0]     old1_c;
  logic [CntW-1:0]      cnt1_c;
  logic [SlotW-1:0]     old2_c;
  logic [CntW-1:0]      cnt2_c;
  logic signed [PosW-1:0] pos_c;
  logic signed [PosW-1:0] cnt_ext_c;
  logic                 bad_off_c;
  logic [SlotW-1:0]     rslot_c;

  logic                 go_data;
  logic                 word_we;
  logic [AddrW-1:0]     word_waddr;
  logic [AddrW-1:0]     word_raddr;
  logic [WordWidth-1:0] word_rdata;
  logic [StatusW-1:0]   res_status;
  logic [CntW-1:0]      res_cnt;
  logic                 upd_meta;
  logic                 clr_one;
  logic                 clr_all;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign proceed       = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_cnt_q, out_word_q, out_status_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MaxEntReset;
    end else if (cfg_we_i) begin
      max_entries_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q    <= s_axis_tdata[2:0];
      unit_q  <= s_axis_tdata[8:3];
      off_q   <= s_axis_tdata[13:9];
      pword_q <= s_axis_tdata[45:14];
    end
  end

  assign unit_ok = int'(unit_q) < NumUnits;

  pbhb_meta_store u_meta (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_take),
    .rd_unit_i (UnitW'(s_axis_tdata[8:3])),
    .wr_i      (meta_wr),
    .rd_o      (meta_rd)
  );

  // ---- log: append, then trim to min(max_entries, Depth) ----
  assign cnt_c   = meta_rd.count;
  assign old_c   = meta_rd.oldest;
  assign limit_c = (int'(max_entries_q) < Depth) ? CntW'(max_entries_q) : CntW'(Depth);

  always_comb begin
    if (cnt_c < CntW'(Depth)) begin
      wslot_c = slot_wrap((CntW+1)'(old_c) + (CntW+1)'(cnt_c));
      old1_c  = old_c;
      cnt1_c  = cnt_c + 1'b1;
    end else begin
      // full ring: overwrite the oldest
      wslot_c = old_c;
      old1_c  = slot_wrap((CntW+1)'(old_c) + (CntW+1)'(1));
      cnt1_c  = CntW'(Depth);
    end
    if (cnt1_c > limit_c) begin
      old2_c = slot_wrap((CntW+1)'(old1_c) + (CntW+1)'(cnt1_c - limit_c));
      cnt2_c = limit_c;
    end else begin
      old2_c = old1_c;
      cnt2_c = cnt1_c;
    end
  end

  // ---- read: offset from oldest, negative counts back from newest ----
  assign cnt_ext_c = $signed(PosW'(cnt_c));
  assign pos_c     = (off_q >= 0) ? PosW'(off_q) : cnt_ext_c + PosW'(off_q);
  assign bad_off_c = (pos_c < 0) || (pos_c >= cnt_ext_c);
  assign rslot_c   = slot_wrap((CntW+1)'(old_c) + (CntW+1)'($unsigned(pos_c)));

  assign word_waddr = AddrW'(unit_q) * AddrW'(Depth) + AddrW'(wslot_c);
  assign word_raddr = AddrW'(unit_q) * AddrW'(Depth) + AddrW'(rslot_c);

  always_comb begin
    res_status = STAT_OK;
    res_cnt    = '0;
    go_data    = 1'b0;
    upd_meta   = 1'b0;
    clr_one    = 1'b0;
    clr_all    = 1'b0;
    unique case (op_q)
      OP_LOG: begin
        if (!unit_ok) begin
          res_status = STAT_NO_KEY;
        end else begin
          upd_meta = 1'b1;
          res_cnt  = cnt2_c;
        end
      end
      OP_READ, OP_COUNT: begin
        if (!unit_ok || !meta_rd.present) begin
          res_status = STAT_NO_KEY;
        end else begin
          res_cnt = cnt_c;
          if (op_q == OP_READ) begin
            if (bad_off_c) begin
              res_status = STAT_RANGE;
            end else begin
              go_data = 1'b1;
            end
          end
        end
      end
      OP_CLR_KEY: clr_one = unit_ok;
      OP_CLR_ALL: clr_all = 1'b1;
      default: ;
    endcase
  end

  // writes commit only when the result can be registered
  assign load_meta = (state_q == ST_META) && !go_data && proceed;
  assign load_data = (state_q == ST_DATA) && proceed;
  assign word_we   = load_meta && upd_meta;

  assign meta_wr.we      = word_we;
  assign meta_wr.clr_one = load_meta && clr_one;
  assign meta_wr.clr_all = load_meta && clr_all;
  assign meta_wr.unit    = UnitW'(unit_q);
  assign meta_wr.oldest  = old2_c;
  assign meta_wr.count   = cnt2_c;

  pbhb_word_store u_words (
    .clk_i   (clk_i),
    .we_i    (word_we),
    .waddr_i (word_waddr),
    .wdata_i (WordWidth'(pword_q)),
    .re_i    ((state_q == ST_META) && go_data),
    .raddr_i (word_raddr),
    .rdata_o (word_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      out_status_q <= STAT_OK;
      out_word_q   <= '0;
      out_cnt_q    <= '0;
    end else begin
      // a load only happens once the held result is gone or leaves now
      if (load_meta || load_data) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (load_meta) begin
        out_status_q <= res_status;
        out_word_q   <= '0;
        out_cnt_q    <= EntCntW'(res_cnt);
      end else if (load_data) begin
        out_status_q <= STAT_OK;
        out_word_q   <= ReadWordW'(word_rdata);
        out_cnt_q    <= EntCntW'(cnt_c);
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) state_q <= ST_META;
        end
        ST_META: begin
          if (go_data) begin
            state_q <= ST_DATA;
          end else if (proceed) begin
            state_q <= ST_IDLE;
          end
        end
        ST_DATA: begin
          if (proceed) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `PBHB_ASSERT(a_word_we_log, word_we |-> (state_q == ST_META) && (op_q == OP_LOG))
  `PBHB_ASSERT_ALWAYS(a_cnt_bound, m_axis_tvalid |-> (out_cnt_q <= EntCntW'(Depth)))
  `PBHB_ASSERT(a_log_limit, (word_we |=> (out_cnt_q <= $past(EntCntW'(limit_c)))))
  `PBHB_ASSERT(a_err_zero, (m_axis_tvalid && (out_status_q != STAT_OK)) |-> (out_word_q == '0))

endmodule
